// File: rtl/ttw_pkg.sv
package ttw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int CHAR_W    = 8;
   localparam int INDEX_W   = 11;
   localparam int COLOR_W   = 8;
   localparam int VALUE_W   = 16;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam int RSP_ROW_LSB    = VALUE_W;
   localparam int RSP_COL_LSB    = VALUE_W + ROW_OUT_W;
   localparam int RSP_SCROLL_BIT = VALUE_W + ROW_OUT_W + COL_OUT_W;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_READ,
      OP_READ_NONE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   char_code;
      logic [INDEX_W-1:0]  cell_index;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

// File: rtl/ttw_ram.sv
module ttw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ttw_front.sv
module ttw_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept_en,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,   // cmd
   input  logic [ttw_pkg::REQ_DATA_W-1:0]  req_tdata,   // char_code, cell_index
   input  logic                            pop,
   output ttw_pkg::head_type               head
);
   import ttw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   item_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   item_type           new_item;
   logic               push;

   // classify the item so the back end only dispatches
   always_comb begin
      new_item.char_code  = req_tdata[CHAR_W-1:0];
      new_item.cell_index = req_tdata[CHAR_W +: INDEX_W];
      if (req_tuser) begin
         if (32'(new_item.cell_index) < CELLS) begin
            new_item.op = OP_READ;
         end else begin
            new_item.op = OP_READ_NONE;
         end
      end else if (new_item.char_code == NEWLINE_CODE) begin
         new_item.op = OP_NEWLINE;
      end else begin
         new_item.op = OP_PUT;
      end
   end

   assign req_tready = accept_en && (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

endmodule

// File: rtl/ttw_back.sv
module ttw_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ttw_pkg::COLOR_W-1:0]     csr_wr_data,
   input  ttw_pkg::head_type               head,
   output logic                            pop,
   output logic                            ready,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ttw_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ttw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_DRAIN,
      ST_BLANK
   } state_type;

   state_type               state_ff, state_in;
   logic [COLOR_W-1:0]      color_ff, color_in;
   logic [COLOR_W-1:0]      blank_color_ff, blank_color_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ADDR_W-1:0]       base_ff, base_in;
   logic [ADDR_W-1:0]       sweep_ff, sweep_in;
   logic                    wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]       wr_addr_ff, wr_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    ram_we, ram_re;
   logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
   logic [VALUE_W-1:0]      ram_wdata, ram_rdata;

   logic                    can_issue;
   logic [COL_W:0]          col_inc;
   logic                    last_row;
   logic                    wrap;

   ttw_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CELLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(
      input logic [VALUE_W-1:0]   value,
      input logic [ROW_OUT_W-1:0] row,
      input logic [COL_OUT_W-1:0] col,
      input logic                 scrolled
   );
      pack_rsp = RSP_DATA_W'({scrolled, col, row, value});
   endfunction

   assign can_issue = head.valid && (!rsp_valid_ff || rsp_tready);
   assign col_inc   = {1'b0, col_ff} + (COL_W+1)'(1);
   assign last_row  = (row_ff == ROW_W'(ROWS - 1));
   assign wrap      = (head.item.op == OP_NEWLINE) || (col_inc == (COL_W+1)'(COLUMNS));

   always_comb begin
      state_in       = state_ff;
      color_in       = csr_wr_en ? csr_wr_data : color_ff;
      blank_color_in = blank_color_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      base_in        = base_ff;
      sweep_in       = sweep_ff;
      wr_pend_in     = wr_pend_ff;
      wr_addr_in     = wr_addr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      pop            = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = sweep_ff;
      ram_wdata      = {blank_color_ff, SPACE_CODE};
      ram_re         = 1'b0;
      ram_raddr      = sweep_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = {RESET_COLOR, SPACE_CODE};
            if (sweep_ff == ADDR_W'(CELLS - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (can_issue) begin
               pop = 1'b1;
               case (head.item.op)
                  OP_READ: begin
                     ram_re    = 1'b1;
                     ram_raddr = ADDR_W'(head.item.cell_index);
                     state_in  = ST_READ;
                  end
                  OP_READ_NONE: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pack_rsp('0, ROW_OUT_W'(row_ff),
                                             COL_OUT_W'(col_ff), 1'b0);
                  end
                  OP_PUT, OP_NEWLINE: begin
                     if (head.item.op == OP_PUT) begin
                        ram_we    = 1'b1;
                        ram_waddr = base_ff + ADDR_W'(col_ff);
                        ram_wdata = {color_ff, head.item.char_code};
                     end
                     rsp_valid_in = 1'b1;
                     if (!wrap) begin
                        col_in      = COL_W'(col_inc);
                        rsp_data_in = pack_rsp('0, ROW_OUT_W'(row_ff),
                                               COL_OUT_W'(col_inc), 1'b0);
                     end else if (last_row) begin
                        // report now, rewrite the rows behind the result
                        col_in         = '0;
                        sweep_in       = ADDR_W'(COLUMNS);
                        blank_color_in = color_ff;
                        state_in       = ST_SCROLL;
                        rsp_data_in    = pack_rsp('0, ROW_OUT_W'(row_ff), '0, 1'b1);
                     end else begin
                        col_in      = '0;
                        row_in      = row_ff + ROW_W'(1);
                        base_in     = base_ff + ADDR_W'(COLUMNS);
                        rsp_data_in = pack_rsp('0, ROW_OUT_W'(row_in), '0, 1'b0);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = pack_rsp(ram_rdata, ROW_OUT_W'(row_ff),
                                    COL_OUT_W'(col_ff), 1'b0);
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            // read one row below, write it back in the next cycle
            ram_re     = 1'b1;
            wr_pend_in = 1'b1;
            wr_addr_in = sweep_ff - ADDR_W'(COLUMNS);
            if (wr_pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_addr_ff;
               ram_wdata = ram_rdata;
            end
            if (sweep_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            ram_we     = 1'b1;
            ram_waddr  = wr_addr_ff;
            ram_wdata  = ram_rdata;
            wr_pend_in = 1'b0;
            sweep_in   = ADDR_W'(CELLS - COLUMNS);
            state_in   = ST_BLANK;
         end
         ST_BLANK: begin
            ram_we = 1'b1;
            if (sweep_ff == ADDR_W'(CELLS - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      blank_color_ff <= blank_color_in;
      wr_addr_ff     <= wr_addr_in;
      rsp_data_ff    <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         color_ff     <= RESET_COLOR;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         sweep_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         color_ff     <= color_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         sweep_ff     <= sweep_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign ready      = (state_ff != ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/text_terminal_writer_top.sv
// A put, newline or out-of-range read passes the front queue and the result register; an
// in-range read also passes the registered screen RAM read and state ST_READ.
// The back end takes the next item while the result register drains; an in-range read holds
// it through ST_READ, a scroll while the RAM copies each row up and blanks the last row.
// Reset (synchronous, active high) starts a clearing pass that fills the screen with
// spaces in color 0x07; req_tready stays low meanwhile.
module text_terminal_writer_top #(
   parameter int COLUMNS = ttw_pkg::COLUMNS_DEF,
   parameter int ROWS    = ttw_pkg::ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ttw_pkg::COLOR_W-1:0]     csr_wr_data,  // text_color
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,    // cmd
   input  logic [ttw_pkg::REQ_DATA_W-1:0]  req_tdata,    // char_code, cell_index
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cell_value, cursor_row_out, cursor_column_out, scrolled
   output logic [ttw_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ttw_pkg::*;

   head_type head;
   logic     pop;
   logic     ready;

   ttw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept_en  (ready),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .head       (head)
   );

   ttw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (head),
      .pop         (pop),
      .ready       (ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// File: rtl/ttw_checker.sv
module ttw_checker #(
   parameter int COLUMNS = ttw_pkg::COLUMNS_DEF,
   parameter int ROWS    = ttw_pkg::ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [ttw_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ttw_pkg::*;

   logic [VALUE_W-1:0]   value;
   logic [ROW_OUT_W-1:0] row;
   logic [COL_OUT_W-1:0] col;
   logic                 scrolled;

   assign value    = rsp_tdata[VALUE_W-1:0];
   assign row      = rsp_tdata[RSP_ROW_LSB +: ROW_OUT_W];
   assign col      = rsp_tdata[RSP_COL_LSB +: COL_OUT_W];
   assign scrolled = rsp_tdata[RSP_SCROLL_BIT];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(row) < ROWS) && (32'(col) < COLUMNS))
      else $error("cursor outside the screen");

   a_scroll_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && scrolled |->
         (row == ROW_OUT_W'(ROWS - 1)) && (col == '0) && (value == '0))
      else $error("scroll result not at start of bottom row");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind text_terminal_writer_top ttw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
